/* design/link_connection_supervisor_core_macros.svh */
// Assertion macros used by the link connection supervisor top level.
`ifndef LINK_CONNECTION_SUPERVISOR_CORE_MACROS_SVH
`define LINK_CONNECTION_SUPERVISOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lcs_pkg.sv */
// Types, codes and constants of the link connection supervisor.
package lcs_pkg;

  localparam int CNT_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] CONNECT_TIMEOUT_RST  = CNT_W'(15000);
  localparam logic [CNT_W-1:0] RECONNECT_WINDOW_RST = CNT_W'(60000);
  localparam logic [CNT_W-1:0] RETRY_INTERVAL_RST   = CNT_W'(10000);
  localparam logic [CNT_W-1:0] HOLD_TIME_RST        = CNT_W'(5000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONNECT_TIMEOUT  = 2'd0,
    CFG_RECONNECT_WINDOW = 2'd1,
    CFG_RETRY_INTERVAL   = 2'd2,
    CFG_HOLD_TIME        = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_DISC         = 3'd0,
    MODE_CONNECTING   = 3'd1,
    MODE_CONNECTED    = 3'd2,
    MODE_RECONNECTING = 3'd3,
    MODE_FAILED       = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_START_STA     = 3'd1,
    ACT_START_AP      = 3'd2,
    ACT_DROP_START_AP = 3'd3,
    ACT_STOP_AP       = 3'd4,
    ACT_RETRY         = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CRES_NONE     = 2'd0,
    CRES_ACCEPTED = 2'd1,
    CRES_REJECTED = 2'd2
  } cres_t;

  typedef enum logic [1:0] {
    BACT_NONE    = 2'd0,
    BACT_CLEAR   = 2'd1,
    BACT_RESTART = 2'd2
  } bact_t;

  typedef struct packed {
    logic [CNT_W-1:0] connect_timeout_ms;
    logic [CNT_W-1:0] reconnect_window_ms;
    logic [CNT_W-1:0] retry_interval_ms;
    logic [CNT_W-1:0] hold_time_ms;
  } lcs_cfg_t;

  typedef struct packed {
    logic begin_request;
    logic saved_config_present;
    logic link_up;
    logic button_pressed;
    logic connect_request;
    logic ssid_empty;
  } lcs_item_t;

  typedef struct packed {
    mode_t            link_mode;
    logic [CNT_W-1:0] connect_elapsed;
    logic [CNT_W-1:0] reconnect_window_elapsed;
    logic [CNT_W-1:0] retry_elapsed;
    logic             button_down;
    logic             reset_confirmed;
    logic [CNT_W-1:0] hold_elapsed;
  } lcs_state_t;

  typedef struct packed {
    mode_t   link_state;
    action_t link_action;
    cres_t   connect_result;
    bact_t   button_action;
  } lcs_result_t;

  localparam lcs_state_t STATE_RESET = '{MODE_DISC, '0, '0, '0, 1'b0, 1'b0, '0};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

/* design/lcs_cfg.sv */
// Configuration register file of the link connection supervisor.
module lcs_cfg
  import lcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output lcs_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_timeout_ms  <= CONNECT_TIMEOUT_RST;
      cfg.reconnect_window_ms <= RECONNECT_WINDOW_RST;
      cfg.retry_interval_ms   <= RETRY_INTERVAL_RST;
      cfg.hold_time_ms        <= HOLD_TIME_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CONNECT_TIMEOUT:  cfg.connect_timeout_ms  <= cfg_data;
        CFG_RECONNECT_WINDOW: cfg.reconnect_window_ms <= cfg_data;
        CFG_RETRY_INTERVAL:   cfg.retry_interval_ms   <= cfg_data;
        CFG_HOLD_TIME:        cfg.hold_time_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/lcs_step.sv */
// Next-state and result logic for one supervisor tick.
module lcs_step
  import lcs_pkg::*;
(
  input  lcs_state_t  cur,
  input  lcs_cfg_t    cfg,
  input  lcs_item_t   item,
  output lcs_state_t  nxt,
  output lcs_result_t res
);

  logic restart;

  always_comb begin
    nxt = cur;
    // Every counter advances first; starting one sets it back to zero.
    nxt.connect_elapsed          = sat_inc(cur.connect_elapsed);
    nxt.reconnect_window_elapsed = sat_inc(cur.reconnect_window_elapsed);
    nxt.retry_elapsed            = sat_inc(cur.retry_elapsed);
    nxt.hold_elapsed             = sat_inc(cur.hold_elapsed);
    res.link_action    = ACT_NONE;
    res.connect_result = CRES_NONE;
    res.button_action  = BACT_NONE;
    restart            = 1'b0;

    if (item.begin_request) begin
      if (item.saved_config_present) begin
        nxt.link_mode       = MODE_CONNECTING;
        nxt.connect_elapsed = '0;
        res.link_action     = ACT_START_STA;
      end else begin
        res.link_action = ACT_START_AP;
      end
    end else begin
      if (item.connect_request) begin
        if (item.ssid_empty) begin
          res.connect_result = CRES_REJECTED;
        end else begin
          res.connect_result  = CRES_ACCEPTED;
          nxt.link_mode       = MODE_CONNECTING;
          nxt.connect_elapsed = '0;
        end
      end

      if (item.button_pressed && !cur.button_down) begin
        nxt.button_down     = 1'b1;
        nxt.reset_confirmed = 1'b0;
        nxt.hold_elapsed    = '0;
      end
      if (item.button_pressed && nxt.button_down && !nxt.reset_confirmed &&
          nxt.hold_elapsed >= cfg.hold_time_ms) begin
        nxt.reset_confirmed = 1'b1;
        res.button_action   = BACT_CLEAR;
      end
      if (!item.button_pressed && cur.button_down) begin
        nxt.button_down = 1'b0;
        if (cur.reset_confirmed) begin
          res.button_action = BACT_RESTART;
          restart           = 1'b1;
        end
      end

      if (restart) begin
        nxt = STATE_RESET;
      end else begin
        unique case (nxt.link_mode)
          MODE_CONNECTING: begin
            if (item.link_up) begin
              nxt.link_mode   = MODE_CONNECTED;
              res.link_action = ACT_STOP_AP;
            end else if (nxt.connect_elapsed >= cfg.connect_timeout_ms) begin
              nxt.link_mode                = MODE_FAILED;
              res.link_action              = ACT_DROP_START_AP;
              nxt.reconnect_window_elapsed = '0;
              nxt.retry_elapsed            = '0;
            end
          end
          MODE_CONNECTED: begin
            if (!item.link_up) begin
              nxt.link_mode                = MODE_RECONNECTING;
              nxt.reconnect_window_elapsed = '0;
              nxt.retry_elapsed            = '0;
            end
          end
          MODE_RECONNECTING: begin
            if (item.link_up) begin
              nxt.link_mode   = MODE_CONNECTED;
              res.link_action = ACT_STOP_AP;
            end else if (nxt.reconnect_window_elapsed >= cfg.reconnect_window_ms) begin
              nxt.link_mode                = MODE_FAILED;
              res.link_action              = ACT_START_AP;
              nxt.reconnect_window_elapsed = '0;
              nxt.retry_elapsed            = '0;
            end else if (nxt.retry_elapsed >= cfg.retry_interval_ms) begin
              nxt.retry_elapsed = '0;
              res.link_action   = ACT_RETRY;
            end
          end
          MODE_FAILED: begin
            if (item.link_up) begin
              nxt.link_mode   = MODE_CONNECTED;
              res.link_action = ACT_STOP_AP;
            end else if (nxt.retry_elapsed >= cfg.retry_interval_ms) begin
              nxt.retry_elapsed = '0;
              res.link_action   = ACT_RETRY;
            end
          end
          default: ;
        endcase
      end
    end

    res.link_state = nxt.link_mode;
  end

endmodule

/* design/link_connection_supervisor_core.sv */
// Top level of the link connection supervisor: request pipeline and supervisor state.
//
// The link connection supervisor takes one tick request per millisecond (or at any
// rate the caller likes) carrying the link status, the reset button level and the
// begin and connect request flags, and returns one result per request: the link mode
// after the tick, the link action to perform, the outcome of a connect request and
// the button action. A request may be accepted in every clock cycle while the result
// channel does not stall. An accepted request is held in the input register and then
// moves into the result register, whose outputs hold it until it is taken. The
// supervisor state (mode, elapsed counters, button tracking) is updated as a request
// moves from the input register into the result register, so that update loop sets
// the figure of one request per cycle. The input side stalls only when the input
// register is full and the result register cannot be emptied. Elapsed counters are
// 20 bits wide and saturate; a time is up once a counter reaches its register, so a
// register written as zero makes that time up at once. The four timing registers
// are written through the plain write port and should only be changed while no
// request is in flight. A restart on button release returns all supervisor state to
// its reset values but keeps the timing registers.
`include "link_connection_supervisor_core_macros.svh"

module link_connection_supervisor_core
  import lcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  // Tick request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 begin_request,
  input  logic                 saved_config_present,
  input  logic                 link_up,
  input  logic                 button_pressed,
  input  logic                 connect_request,
  input  logic                 ssid_empty,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           link_state,
  output logic [2:0]           link_action,
  output logic [1:0]           connect_result,
  output logic [1:0]           button_action
);

  lcs_cfg_t    cfg;
  lcs_item_t   s1_item;
  logic        s1_valid;
  lcs_state_t  state;
  lcs_state_t  state_next;
  lcs_result_t step_res;
  lcs_result_t out_res;
  logic        out_free;
  logic        s1_fire;
  logic        in_fire;

  lcs_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  // The result register can take a new result when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  lcs_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .item (s1_item),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Control state and the supervisor state proper.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted request and the finished result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.begin_request        <= begin_request;
      s1_item.saved_config_present <= saved_config_present;
      s1_item.link_up              <= link_up;
      s1_item.button_pressed       <= button_pressed;
      s1_item.connect_request      <= connect_request;
      s1_item.ssid_empty           <= ssid_empty;
    end
    if (s1_fire) begin
      out_res <= step_res;
    end
  end

  assign link_state     = out_res.link_state;
  assign link_action    = out_res.link_action;
  assign connect_result = out_res.connect_result;
  assign button_action  = out_res.button_action;

  // A restart on release must leave the supervisor in its reset state.
  `LCS_ASSERT_NEXT(a_restart_clears, clk, rst,
                   s1_fire && step_res.button_action == BACT_RESTART,
                   state.link_mode == MODE_DISC && !state.button_down &&
                   state.hold_elapsed == '0,
                   "restart did not clear supervisor state")
  // A confirmed hold only exists while the button is still down.
  `LCS_ASSERT_IMP(a_confirm_needs_hold, clk, rst,
                  state.reset_confirmed, state.button_down,
                  "reset confirmed with button released")
  // Stopping the access point is only ever reported on reaching connected.
  `LCS_ASSERT_IMP(a_stop_ap_connected, clk, rst,
                  out_valid && link_action == ACT_STOP_AP, link_state == MODE_CONNECTED,
                  "stop AP reported outside connected mode")
  // A begin tick carries no connect or button outcome.
  `LCS_ASSERT_NEXT(a_begin_quiet, clk, rst,
                   s1_fire && s1_item.begin_request,
                   connect_result == CRES_NONE && button_action == BACT_NONE,
                   "begin tick reported a side outcome")

endmodule
